FILE: sv/bga_pkg.sv
// Shared constants and types for the battery gauge ADC averaging unit.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none

package bga_pkg;

  localparam int unsigned SAMPLE_W  = 12;
  localparam int unsigned SUM_W     = 20;
  localparam int unsigned CNT_W     = 8;
  localparam int unsigned GAIN_W    = 16;
  localparam int unsigned OFFSET_W  = 10;
  localparam int unsigned VOLT_W    = 16;
  localparam int unsigned PCT_W     = 10;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CFG_DAT_W = 16;

  // sum * 3300 fits 32 bits, times the 16-bit gain fits 48 bits
  localparam int unsigned MCAND_W = 32;
  localparam int unsigned PROD_W  = 48;
  localparam int unsigned DEN_W   = 32;

  localparam logic [11:0] SCALE_MV = 12'd3300;

  localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 8'd1;

  localparam logic [GAIN_W-1:0]   GAIN_RESET   = 16'd8192;
  localparam logic [OFFSET_W-1:0] OFFSET_RESET = 10'd100;

  localparam logic [VOLT_W-1:0] FULL_MV  = 16'd4200;
  localparam logic [VOLT_W-1:0] KNEE_MV  = 16'd3200;
  localparam logic [VOLT_W-1:0] EMPTY_MV = 16'd3000;
  localparam logic [VOLT_W-1:0] VOLT_MAX = 16'hFFFF;

  localparam logic [PCT_W-1:0] PCT_FULL = 10'd1000;
  localparam logic [PCT_W-1:0] PCT_KNEE = 10'd100;

  // floor(x/10) = (x*6554)>>16 for x < 9000; floor(y/25) = (y*2622)>>16 for y < 2500
  localparam logic [12:0] RECIP_10 = 13'd6554;
  localparam logic [11:0] RECIP_25 = 12'd2622;

endpackage

`default_nettype wire

FILE: sv/bga_mul.sv
// Bit-serial shift-add multiplier: one multiplier bit per cycle.
// Depends on bga_pkg for operand and product widths.
`default_nettype none

module bga_mul (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [bga_pkg::MCAND_W-1:0]  mcand_in,
  input  wire logic [bga_pkg::GAIN_W-1:0]   mplier_in,
  output logic                              done,
  output logic [bga_pkg::PROD_W-1:0]        product
);

  logic                         busy;
  logic [3:0]                   step;
  logic [bga_pkg::PROD_W-1:0]   mcand;
  logic [bga_pkg::GAIN_W-1:0]   mplier;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy    <= 1'b1;
        step    <= '0;
        product <= '0;
        mcand   <= bga_pkg::PROD_W'(mcand_in);
        mplier  <= mplier_in;
      end else if (busy) begin
        if (mplier[0]) begin
          product <= product + mcand;
        end
        mcand  <= {mcand[bga_pkg::PROD_W-2:0], 1'b0};
        mplier <= {1'b0, mplier[bga_pkg::GAIN_W-1:1]};
        step   <= step + 4'd1;
        if (step == 4'(bga_pkg::GAIN_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/bga_div.sv
// Restoring divider by a constant divisor, one quotient bit per cycle.
// Depends on bga_pkg for dividend and divisor widths.
`default_nettype none

module bga_div #(
  parameter logic [31:0] DIVISOR = 32'd268369920
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [bga_pkg::PROD_W-1:0]  dividend,
  output logic                             done,
  output logic [bga_pkg::PROD_W-1:0]       quotient
);

  logic                        busy;
  logic [5:0]                  step;
  logic [bga_pkg::DEN_W-1:0]   rem;
  logic [bga_pkg::DEN_W:0]     trial;
  logic                        fits;

  // shift the next dividend bit into the partial remainder
  assign trial = {rem, quotient[bga_pkg::PROD_W-1]};
  assign fits  = (trial >= {1'b0, DIVISOR});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        step     <= '0;
        rem      <= '0;
        quotient <= dividend;
      end else if (busy) begin
        if (fits) begin
          rem <= bga_pkg::DEN_W'(trial - {1'b0, DIVISOR});
        end else begin
          rem <= trial[bga_pkg::DEN_W-1:0];
        end
        quotient <= {quotient[bga_pkg::PROD_W-2:0], fits};
        step     <= step + 6'd1;
        if (step == 6'(bga_pkg::PROD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/bga_charge.sv
// State-of-charge curve: maps voltage to tenths of a percent.
// Depends on bga_pkg for thresholds and reciprocal constants.
`default_nettype none

module bga_charge (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [bga_pkg::VOLT_W-1:0]  volt,
  output logic                             done,
  output logic [bga_pkg::PCT_W-1:0]        pct
);

  typedef enum logic [1:0] {
    RG_EMPTY,
    RG_LOW,
    RG_LINEAR,
    RG_FULL
  } region_t;

  region_t                      region;
  logic                         busy;
  logic [13:0]                  lin;     // (v - 3200) * 9
  logic [15:0]                  sq;      // (v - 3000)^2
  logic [bga_pkg::VOLT_W-1:0]   knee_diff;
  logic [bga_pkg::VOLT_W-1:0]   empty_diff;
  logic [26:0]                  lin_prod;
  logic [23:0]                  sq_prod;

  assign knee_diff  = volt - bga_pkg::KNEE_MV;
  assign empty_diff = volt - bga_pkg::EMPTY_MV;
  assign lin_prod   = 27'(lin) * 27'(bga_pkg::RECIP_10);
  assign sq_prod    = 24'(sq[15:4]) * 24'(bga_pkg::RECIP_25);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        lin  <= 14'(knee_diff[9:0]) * 14'd9;
        sq   <= 16'(empty_diff[7:0]) * 16'(empty_diff[7:0]);
        if (volt >= bga_pkg::FULL_MV) begin
          region <= RG_FULL;
        end else if (volt <= bga_pkg::EMPTY_MV) begin
          region <= RG_EMPTY;
        end else if (volt >= bga_pkg::KNEE_MV) begin
          region <= RG_LINEAR;
        end else begin
          region <= RG_LOW;
        end
      end else if (busy) begin
        busy <= 1'b0;
        done <= 1'b1;
        case (region)
          RG_FULL:   pct <= bga_pkg::PCT_FULL;
          RG_EMPTY:  pct <= '0;
          RG_LINEAR: pct <= bga_pkg::PCT_KNEE + lin_prod[25:16];
          RG_LOW:    pct <= 10'(sq_prod[23:16]);
          default:   pct <= '0;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/battery_gauge_adc_average_unit.sv
// Battery gauge: a sample that does not close a batch is accumulated while idle; the
// closing sample holds s_tready low while the batch goes through setup, the
// bit-serial multiply, the bit-serial divide (one bit a cycle each), saturation and
// the charge curve. Its result beat then follows, later while an older result is
// still unread. Reset (rst, synchronous, high) clears sum, count, state and output
// valid and loads divider_gain = 8192 (2.0) and offset_mv = 100.
`default_nettype none

module battery_gauge_adc_average_unit #(
  parameter int unsigned SAMPLES = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // sample stream
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [15:0]                      s_tdata,   // [11:0] sample
  // result stream
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic [31:0]                           m_tdata,   // [15:0] voltage_mv,
                                                           // [25:16] percent_tenths
  // configuration writes
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [bga_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [bga_pkg::CFG_DAT_W-1:0]    cfg_data
);

  // full-scale divisor: SAMPLES * 4095 * 4096, folds the average and code scale
  localparam logic [63:0] DEN_FULL = 64'(SAMPLES) * 64'd4095 * 64'd4096;
  localparam logic [31:0] DIVISOR  = DEN_FULL[31:0];

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_MUL,
    ST_DIV,
    ST_CHG_START,
    ST_CHG,
    ST_OUT
  } state_t;

  state_t                           state;
  logic [bga_pkg::SUM_W-1:0]        sample_sum;
  logic [bga_pkg::CNT_W-1:0]        sample_count;
  logic [bga_pkg::SUM_W-1:0]        batch_sum;
  logic [bga_pkg::GAIN_W-1:0]       divider_gain;
  logic [bga_pkg::OFFSET_W-1:0]     offset_mv;
  logic [bga_pkg::VOLT_W-1:0]       volt;
  logic [bga_pkg::PCT_W-1:0]        pct_hold;

  logic                             accept;
  logic [bga_pkg::SUM_W-1:0]        sum_next;
  logic [bga_pkg::CNT_W:0]          count_next;
  logic                             batch_end;

  logic [bga_pkg::MCAND_W-1:0]      mcand;
  logic                             mul_done;
  logic [bga_pkg::PROD_W-1:0]       product;
  logic                             div_done;
  logic [bga_pkg::PROD_W-1:0]       quotient;
  logic                             chg_done;
  logic [bga_pkg::PCT_W-1:0]        chg_pct;
  logic [bga_pkg::VOLT_W:0]         volt_sum;
  logic                             out_free;

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;

  assign sum_next   = sample_sum + bga_pkg::SUM_W'(s_tdata[bga_pkg::SAMPLE_W-1:0]);
  assign count_next = {1'b0, sample_count} + 9'd1;
  assign batch_end  = (count_next == 9'(SAMPLES));

  // one multiply into the multiplier's operand register: sum * 3300
  assign mcand = bga_pkg::MCAND_W'(batch_sum) * bga_pkg::MCAND_W'(bga_pkg::SCALE_MV);

  // offset plus scaled voltage, saturated at 16 bits
  assign volt_sum = 17'(quotient[bga_pkg::VOLT_W-1:0]) + 17'(offset_mv);
  assign out_free = !m_tvalid || m_tready;

  bga_mul u_mul (
    .clk       (clk),
    .rst       (rst),
    .start     (state == ST_SCALE),
    .mcand_in  (mcand),
    .mplier_in (divider_gain),
    .done      (mul_done),
    .product   (product)
  );

  bga_div #(
    .DIVISOR (DIVISOR)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (mul_done),
    .dividend (product),
    .done     (div_done),
    .quotient (quotient)
  );

  bga_charge u_charge (
    .clk   (clk),
    .rst   (rst),
    .start (state == ST_CHG_START),
    .volt  (volt),
    .done  (chg_done),
    .pct   (chg_pct)
  );

  // configuration registers; unknown indexes drop
  always_ff @(posedge clk) begin
    if (rst) begin
      divider_gain <= bga_pkg::GAIN_RESET;
      offset_mv    <= bga_pkg::OFFSET_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == bga_pkg::CFG_GAIN) begin
        divider_gain <= cfg_data;
      end else if (cfg_index == bga_pkg::CFG_OFFSET) begin
        offset_mv <= cfg_data[bga_pkg::OFFSET_W-1:0];
      end
    end
  end

  // sequencer: accumulate, then walk the batch through multiply, divide, curve
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      sample_sum   <= '0;
      sample_count <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      // drop a taken beat; ST_OUT decides the valid itself
      if (m_tvalid && m_tready && state != ST_OUT) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (batch_end) begin
              batch_sum    <= sum_next;
              sample_sum   <= '0;
              sample_count <= '0;
              state        <= ST_SCALE;
            end else begin
              sample_sum   <= sum_next;
              sample_count <= count_next[bga_pkg::CNT_W-1:0];
            end
          end
        end
        ST_SCALE: state <= ST_MUL;
        ST_MUL: begin
          if (mul_done) begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            if (quotient[bga_pkg::PROD_W-1:bga_pkg::VOLT_W] != '0 ||
                volt_sum[bga_pkg::VOLT_W]) begin
              volt <= bga_pkg::VOLT_MAX;
            end else begin
              volt <= volt_sum[bga_pkg::VOLT_W-1:0];
            end
            state <= ST_CHG_START;
          end
        end
        ST_CHG_START: state <= ST_CHG;
        ST_CHG: begin
          if (chg_done) begin
            pct_hold <= chg_pct;
            state    <= ST_OUT;
          end
        end
        ST_OUT: begin
          // hold the result until the output register is free
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {6'd0, pct_hold, volt};
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_count_below_batch: assert property (@(posedge clk) disable iff (rst)
    9'(sample_count) < 9'(SAMPLES))
    else $error("sample count reached batch size");

  a_batch_starts_math: assert property (@(posedge clk) disable iff (rst)
    accept && batch_end |=> state == ST_SCALE)
    else $error("closing sample did not start arithmetic");

  a_mul_done_in_mul: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> state == ST_MUL)
    else $error("multiplier finished outside multiply phase");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV)
    else $error("divider finished outside divide phase");

  a_pct_in_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[25:16] <= bga_pkg::PCT_FULL)
    else $error("charge beyond full scale");

endmodule

`default_nettype wire
